>>> rtl/ttf_pkg.sv
// ----------------------------------------------------------------------------
// ttf_pkg
// Types, widths and codes shared by the tangent frame controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package ttf_pkg;

	localparam int COORD_W   = 32;
	localparam int UNIT_W    = 16;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int ACC_W     = PROD_W;
	localparam int MAG_W     = ACC_W - 1;
	localparam int NV_W      = 31;
	localparam int NORM_W    = 31;
	localparam int SUM_W     = 64;
	localparam int ROOT_W    = 32;
	localparam int FRAC_BITS = 14;
	localparam int QUO_W     = 15;
	localparam int DVS_W     = ROOT_W + FRAC_BITS;
	localparam int NUM_W     = DVS_W + 1;
	localparam int SQRT_STEPS = 32;
	localparam int UNIT_Q14  = 16384;

	localparam logic [SUM_W-1:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

	localparam int MI_W = 5;
	localparam logic [MI_W-1:0] MI_DET0 = 5'd0;
	localparam logic [MI_W-1:0] MI_TV0  = 5'd2;
	localparam logic [MI_W-1:0] MI_BV0  = 5'd8;
	localparam logic [MI_W-1:0] MI_N0   = 5'd14;
	localparam logic [MI_W-1:0] MI_SQ0  = 5'd20;
	localparam logic [MI_W-1:0] MI_END  = 5'd23;

	localparam logic [1:0] VEC_T = 2'd0;
	localparam logic [1:0] VEC_B = 2'd1;
	localparam logic [1:0] VEC_N = 2'd2;
	localparam logic [1:0] LAST_COMP = 2'd2;

	localparam logic [3:0] OP_NOP       = 4'd0;
	localparam logic [3:0] OP_CAP1      = 4'd1;
	localparam logic [3:0] OP_CAP2      = 4'd2;
	localparam logic [3:0] OP_CAP3      = 4'd3;
	localparam logic [3:0] OP_LOAD      = 4'd4;
	localparam logic [3:0] OP_ALIGN     = 4'd5;
	localparam logic [3:0] OP_SQRT_INIT = 4'd6;
	localparam logic [3:0] OP_SQRT_STEP = 4'd7;
	localparam logic [3:0] OP_DIV_INIT  = 4'd8;
	localparam logic [3:0] OP_DIV_STEP  = 4'd9;
	localparam logic [3:0] OP_DIV_STORE = 4'd10;
	localparam logic [3:0] OP_OUT       = 4'd11;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [COORD_W-1:0] tex_u;
		logic signed [COORD_W-1:0] tex_v;
		logic                      end_of_mesh;
	} vtx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] u;
		logic signed [COORD_W-1:0] v;
	} coord_t;

	typedef struct packed {
		logic signed [UNIT_W-1:0] tangent_x;
		logic signed [UNIT_W-1:0] tangent_y;
		logic signed [UNIT_W-1:0] tangent_z;
		logic signed [UNIT_W-1:0] binormal_x;
		logic signed [UNIT_W-1:0] binormal_y;
		logic signed [UNIT_W-1:0] binormal_z;
		logic signed [UNIT_W-1:0] normal_x;
		logic signed [UNIT_W-1:0] normal_y;
		logic signed [UNIT_W-1:0] normal_z;
		logic                     degenerate;
	} frame_t;

	typedef struct packed {
		logic [3:0]      op;
		logic            mul_en;
		logic [MI_W-1:0] mul_idx;
		logic [1:0]      vec;
		logic [1:0]      comp;
		logic            degen;
	} cmd_t;

	typedef struct packed {
		logic det_zero;
		logic mag_zero;
		logic aligned;
	} sts_t;

endpackage

>>> rtl/ttf_stream_if.sv
// ----------------------------------------------------------------------------
// ttf_stream_if
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface ttf_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/ttf_dp.sv
// ----------------------------------------------------------------------------
// ttf_dp
// Datapath: vertex store, shared multiplier with accumulators, alignment
// shifter, bitwise square root, restoring divider and result register.
// ----------------------------------------------------------------------------
module ttf_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  ttf_pkg::vtx_t   vtx_data,
	input  ttf_pkg::cmd_t   cmd,
	output ttf_pkg::sts_t   sts,
	output ttf_pkg::frame_t frame_data
);
	import ttf_pkg::*;

	coord_t first_q;
	coord_t second_q;
	logic signed [DIFF_W-1:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [DIFF_W-1:0] e1_q [3];
	logic signed [DIFF_W-1:0] e2_q [3];
	logic signed [ACC_W-1:0]  det_q;
	logic signed [ACC_W-1:0]  tv_q [3];
	logic signed [ACC_W-1:0]  bv_q [3];
	logic signed [NV_W-1:0]   nv_q [3];
	logic signed [UNIT_W-1:0] tq_q [3];
	logic signed [UNIT_W-1:0] bq_q [3];
	logic signed [UNIT_W-1:0] nq_q [3];
	logic [MAG_W-1:0]         mag_q [3];
	logic [2:0]               neg_q;
	logic [SUM_W-1:0]         sum_q, sx_q, sres_q, sbit_q, strial;
	logic [NUM_W-1:0]         rem_q;
	logic [DVS_W-1:0]         dvs_q;
	logic [QUO_W-1:0]         quo_q;
	logic                     mul_en_s1;
	logic [MI_W-1:0]          idx_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [DIFF_W-1:0] mul_a, mul_b;
	logic [1:0]               k, nk, ak, msel;
	logic [NORM_W-1:0]        mk;
	logic signed [ACC_W-1:0]  ld_v [3];
	logic [MAG_W-1:0]         or_v;
	logic                     shr;
	logic [UNIT_W-1:0]        qv;
	logic signed [UNIT_W-1:0] qs;
	logic                     flip;
	frame_t                   frame_q;

	function automatic logic signed [DIFF_W-1:0] diff(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		diff = DIFF_W'(a) - DIFF_W'(b);
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAP1) begin
			first_q <= {vtx_data.pos_x, vtx_data.pos_y, vtx_data.pos_z,
				vtx_data.tex_u, vtx_data.tex_v};
		end
		if (cmd.op == OP_CAP2) begin
			second_q <= {vtx_data.pos_x, vtx_data.pos_y, vtx_data.pos_z,
				vtx_data.tex_u, vtx_data.tex_v};
		end
		if (cmd.op == OP_CAP3) begin
			e1_q[0] <= diff(second_q.x, first_q.x);
			e1_q[1] <= diff(second_q.y, first_q.y);
			e1_q[2] <= diff(second_q.z, first_q.z);
			e2_q[0] <= diff(vtx_data.pos_x, first_q.x);
			e2_q[1] <= diff(vtx_data.pos_y, first_q.y);
			e2_q[2] <= diff(vtx_data.pos_z, first_q.z);
			du1_q   <= diff(second_q.u, first_q.u);
			dv1_q   <= diff(second_q.v, first_q.v);
			du2_q   <= diff(vtx_data.tex_u, first_q.u);
			dv2_q   <= diff(vtx_data.tex_v, first_q.v);
		end
	end

	assign msel = cmd.mul_en ? 2'(cmd.mul_idx - MI_SQ0) : cmd.comp;
	assign mk   = mag_q[msel][NORM_W-1:0];

	always_comb begin
		k     = 2'(6'(cmd.mul_idx - MI_TV0) >> 1);
		nk    = 2'(6'(cmd.mul_idx - MI_N0) >> 1);
		mul_a = '0;
		mul_b = '0;
		if (cmd.mul_idx < MI_TV0) begin
			mul_a = cmd.mul_idx[0] ? du2_q : du1_q;
			mul_b = cmd.mul_idx[0] ? dv1_q : dv2_q;
		end else if (cmd.mul_idx < MI_BV0) begin
			mul_a = cmd.mul_idx[0] ? dv1_q : dv2_q;
			mul_b = cmd.mul_idx[0] ? e2_q[k] : e1_q[k];
		end else if (cmd.mul_idx < MI_N0) begin
			k     = 2'(6'(cmd.mul_idx - MI_BV0) >> 1);
			mul_a = cmd.mul_idx[0] ? du2_q : du1_q;
			mul_b = cmd.mul_idx[0] ? e1_q[k] : e2_q[k];
		end else if (cmd.mul_idx < MI_SQ0) begin
			case (nk)
				2'd0: begin
					mul_a = DIFF_W'(cmd.mul_idx[0] ? tq_q[2] : tq_q[1]);
					mul_b = DIFF_W'(cmd.mul_idx[0] ? bq_q[1] : bq_q[2]);
				end
				2'd1: begin
					mul_a = DIFF_W'(cmd.mul_idx[0] ? tq_q[0] : tq_q[2]);
					mul_b = DIFF_W'(cmd.mul_idx[0] ? bq_q[2] : bq_q[0]);
				end
				2'd2: begin
					mul_a = DIFF_W'(cmd.mul_idx[0] ? tq_q[1] : tq_q[0]);
					mul_b = DIFF_W'(cmd.mul_idx[0] ? bq_q[0] : bq_q[1]);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end else begin
			mul_a = {2'b00, mk};
			mul_b = {2'b00, mk};
		end
	end

	assign prod_c = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_en_s1 <= 1'b0;
		end else begin
			mul_en_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cmd.mul_idx;
		prod_s1 <= prod_c;
	end

	always_comb begin
		if (idx_s1 < MI_BV0) begin
			ak = 2'(6'(idx_s1 - MI_TV0) >> 1);
		end else if (idx_s1 < MI_N0) begin
			ak = 2'(6'(idx_s1 - MI_BV0) >> 1);
		end else begin
			ak = 2'(6'(idx_s1 - MI_N0) >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en_s1) begin
			if (idx_s1 < MI_TV0) begin
				det_q <= idx_s1[0] ? det_q - prod_s1 : prod_s1;
			end else if (idx_s1 < MI_BV0) begin
				tv_q[ak] <= idx_s1[0] ? tv_q[ak] - prod_s1 : prod_s1;
			end else if (idx_s1 < MI_N0) begin
				bv_q[ak] <= idx_s1[0] ? bv_q[ak] - prod_s1 : prod_s1;
			end else if (idx_s1 < MI_SQ0) begin
				nv_q[ak] <= NV_W'(idx_s1[0] ? ACC_W'(nv_q[ak]) - prod_s1 : prod_s1);
			end else begin
				sum_q <= ((idx_s1 == MI_SQ0) ? '0 : sum_q) + prod_s1[SUM_W-1:0];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (cmd.vec)
				VEC_T:   ld_v[i] = tv_q[i];
				VEC_B:   ld_v[i] = bv_q[i];
				default: ld_v[i] = ACC_W'(nv_q[i]);
			endcase
		end
	end

	assign or_v = mag_q[0] | mag_q[1] | mag_q[2];
	assign shr  = |or_v[MAG_W-1:NORM_W];

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			for (int i = 0; i < 3; i++) begin
				neg_q[i] <= ld_v[i][ACC_W-1];
				mag_q[i] <= MAG_W'(ld_v[i][ACC_W-1] ? -ld_v[i] : ld_v[i]);
			end
		end else if (cmd.op == OP_ALIGN) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= shr ? (mag_q[i] >> 1) : (mag_q[i] << 1);
			end
		end
	end

	assign strial = sres_q + sbit_q;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_SQRT_INIT) begin
			sx_q   <= sum_q;
			sres_q <= '0;
			sbit_q <= SQRT_BIT0;
		end else if (cmd.op == OP_SQRT_STEP) begin
			if (sx_q >= strial) begin
				sx_q   <= sx_q - strial;
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DIV_INIT) begin
			rem_q <= NUM_W'({mk, FRAC_BITS'(0)}) + NUM_W'(sres_q[ROOT_W-1:1]);
			dvs_q <= {sres_q[ROOT_W-1:0], FRAC_BITS'(0)};
			quo_q <= '0;
		end else if (cmd.op == OP_DIV_STEP) begin
			if (rem_q >= NUM_W'(dvs_q)) begin
				rem_q <= rem_q - NUM_W'(dvs_q);
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			dvs_q <= dvs_q >> 1;
		end
	end

	assign qv   = {1'b0, quo_q};
	assign flip = (cmd.vec != VEC_N) && det_q[ACC_W-1];
	assign qs   = (neg_q[cmd.comp] ^ flip) ? -$signed(qv) : $signed(qv);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DIV_STORE) begin
			case (cmd.vec)
				VEC_T:   tq_q[cmd.comp] <= qs;
				VEC_B:   bq_q[cmd.comp] <= qs;
				default: nq_q[cmd.comp] <= qs;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			if (cmd.degen) begin
				frame_q            <= '0;
				frame_q.degenerate <= 1'b1;
			end else begin
				frame_q.tangent_x  <= tq_q[0];
				frame_q.tangent_y  <= tq_q[1];
				frame_q.tangent_z  <= tq_q[2];
				frame_q.binormal_x <= bq_q[0];
				frame_q.binormal_y <= bq_q[1];
				frame_q.binormal_z <= bq_q[2];
				frame_q.normal_x   <= nq_q[0];
				frame_q.normal_y   <= nq_q[1];
				frame_q.normal_z   <= nq_q[2];
				frame_q.degenerate <= 1'b0;
			end
		end
	end

	assign frame_data   = frame_q;
	assign sts.det_zero = (det_q == '0);
	assign sts.mag_zero = (or_v == '0);
	assign sts.aligned  = !shr && or_v[NORM_W-1];

endmodule

>>> rtl/ttf_ctrl.sv
// ----------------------------------------------------------------------------
// ttf_ctrl
// Sequencer: vertex slot tracking, command issue for the datapath and the
// result valid flag.
// ----------------------------------------------------------------------------
module ttf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vtx_valid,
	input  logic          vtx_eom,
	output logic          vtx_ready,
	output logic          frame_valid,
	input  logic          frame_ready,
	input  ttf_pkg::sts_t sts,
	output ttf_pkg::cmd_t cmd
);
	import ttf_pkg::*;

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_MUL       = 4'd1;
	localparam logic [3:0] S_MUL_WAIT  = 4'd2;
	localparam logic [3:0] S_CHECK     = 4'd3;
	localparam logic [3:0] S_LOAD      = 4'd4;
	localparam logic [3:0] S_ALIGN     = 4'd5;
	localparam logic [3:0] S_SQ        = 4'd6;
	localparam logic [3:0] S_SQ_WAIT   = 4'd7;
	localparam logic [3:0] S_SQRT_INIT = 4'd8;
	localparam logic [3:0] S_SQRT      = 4'd9;
	localparam logic [3:0] S_DIV_INIT  = 4'd10;
	localparam logic [3:0] S_DIV       = 4'd11;
	localparam logic [3:0] S_DIV_STORE = 4'd12;
	localparam logic [3:0] S_NMUL      = 4'd13;
	localparam logic [3:0] S_NMUL_WAIT = 4'd14;
	localparam logic [3:0] S_FIN       = 4'd15;

	localparam logic [1:0] SLOT_FIRST  = 2'd0;
	localparam logic [1:0] SLOT_SECOND = 2'd1;
	localparam logic [1:0] SLOT_THIRD  = 2'd2;

	logic [3:0]      state_q, state_d;
	logic [1:0]      slot_q, slot_d;
	logic [MI_W-1:0] cnt_q, cnt_d;
	logic [1:0]      comp_q, comp_d;
	logic [1:0]      vec_q, vec_d;
	logic            degen_q, degen_d;
	logic            ovalid_q, ovalid_d;

	always_comb begin
		state_d     = state_q;
		slot_d      = slot_q;
		cnt_d       = cnt_q;
		comp_d      = comp_q;
		vec_d       = vec_q;
		degen_d     = degen_q;
		ovalid_d    = ovalid_q && !frame_ready;
		cmd.op      = OP_NOP;
		cmd.mul_en  = 1'b0;
		cmd.mul_idx = cnt_q;
		cmd.vec     = vec_q;
		cmd.comp    = comp_q;
		cmd.degen   = degen_q;
		unique case (state_q)
			S_IDLE: begin
				if (vtx_valid) begin
					if (slot_q == SLOT_THIRD) begin
						cmd.op  = OP_CAP3;
						slot_d  = SLOT_FIRST;
						cnt_d   = MI_DET0;
						degen_d = 1'b0;
						state_d = S_MUL;
					end else if (slot_q == SLOT_SECOND) begin
						cmd.op = OP_CAP2;
						slot_d = vtx_eom ? SLOT_FIRST : SLOT_THIRD;
					end else begin
						cmd.op = OP_CAP1;
						slot_d = vtx_eom ? SLOT_FIRST : SLOT_SECOND;
					end
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == MI_N0 - 1'b1) begin
					state_d = S_MUL_WAIT;
				end
			end
			S_MUL_WAIT: state_d = S_CHECK;
			S_CHECK: begin
				if (sts.det_zero) begin
					degen_d = 1'b1;
					state_d = S_FIN;
				end else begin
					vec_d   = VEC_T;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.op  = OP_LOAD;
				state_d = S_ALIGN;
			end
			S_ALIGN: begin
				if (sts.mag_zero) begin
					degen_d = 1'b1;
					state_d = S_FIN;
				end else if (sts.aligned) begin
					cnt_d   = MI_SQ0;
					state_d = S_SQ;
				end else begin
					cmd.op = OP_ALIGN;
				end
			end
			S_SQ: begin
				cmd.mul_en = 1'b1;
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == MI_END - 1'b1) begin
					state_d = S_SQ_WAIT;
				end
			end
			S_SQ_WAIT: state_d = S_SQRT_INIT;
			S_SQRT_INIT: begin
				cmd.op  = OP_SQRT_INIT;
				cnt_d   = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = OP_SQRT_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == MI_W'(SQRT_STEPS - 1)) begin
					comp_d  = '0;
					state_d = S_DIV_INIT;
				end
			end
			S_DIV_INIT: begin
				cmd.op  = OP_DIV_INIT;
				cnt_d   = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == MI_W'(QUO_W - 1)) begin
					state_d = S_DIV_STORE;
				end
			end
			S_DIV_STORE: begin
				cmd.op = OP_DIV_STORE;
				if (comp_q == LAST_COMP) begin
					comp_d = '0;
					if (vec_q == VEC_T) begin
						vec_d   = VEC_B;
						state_d = S_LOAD;
					end else if (vec_q == VEC_B) begin
						cnt_d   = MI_N0;
						state_d = S_NMUL;
					end else begin
						state_d = S_FIN;
					end
				end else begin
					comp_d  = comp_q + 1'b1;
					state_d = S_DIV_INIT;
				end
			end
			S_NMUL: begin
				cmd.mul_en = 1'b1;
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == MI_SQ0 - 1'b1) begin
					state_d = S_NMUL_WAIT;
				end
			end
			S_NMUL_WAIT: begin
				vec_d   = VEC_N;
				state_d = S_LOAD;
			end
			S_FIN: begin
				if (!ovalid_q || frame_ready) begin
					cmd.op   = OP_OUT;
					ovalid_d = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			slot_q   <= SLOT_FIRST;
			cnt_q    <= '0;
			comp_q   <= '0;
			vec_q    <= VEC_T;
			degen_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			slot_q   <= slot_d;
			cnt_q    <= cnt_d;
			comp_q   <= comp_d;
			vec_q    <= vec_d;
			degen_q  <= degen_d;
			ovalid_q <= ovalid_d;
		end
	end

	assign vtx_ready   = (state_q == S_IDLE);
	assign frame_valid = ovalid_q;

endmodule

>>> rtl/triangle_tangent_frame.sv
// ----------------------------------------------------------------------------
// triangle_tangent_frame
// The first two vertices of a triangle are only captured. The third vertex
// starts the frame computation, which ends early when the UV determinant is
// zero. The time is set by the shared multiplier, the one-bit alignment
// shifter, the 32-step square root and the 15-step divider run for each of
// tangent, binormal and normal. One triangle is in work at a time. Reset
// clears the slot counter and the result valid.
// ----------------------------------------------------------------------------
module triangle_tangent_frame (
	input logic          clk,
	input logic          arst_n,
	ttf_stream_if.sink   vtx,
	ttf_stream_if.source frame
);
	import ttf_pkg::*;

	cmd_t   cmd;
	sts_t   sts;
	frame_t frame_data;
	logic   vtx_ready;
	logic   frame_valid;

	ttf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.vtx_valid   (vtx.valid),
		.vtx_eom     (vtx.data.end_of_mesh),
		.vtx_ready   (vtx_ready),
		.frame_valid (frame_valid),
		.frame_ready (frame.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	ttf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.vtx_data   (vtx.data),
		.cmd        (cmd),
		.sts        (sts),
		.frame_data (frame_data)
	);

	assign vtx.ready   = vtx_ready;
	assign frame.valid = frame_valid;
	assign frame.data  = frame_data;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.data.degenerate |->
			frame.data.tangent_x == '0 && frame.data.tangent_y == '0 &&
			frame.data.tangent_z == '0 && frame.data.binormal_x == '0 &&
			frame.data.binormal_y == '0 && frame.data.binormal_z == '0 &&
			frame.data.normal_x == '0 && frame.data.normal_y == '0 &&
			frame.data.normal_z == '0)
		else $error("Degenerate transfer carries a nonzero vector.");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && !frame.data.degenerate |->
			$signed(frame.data.tangent_x) <= UNIT_Q14 &&
			$signed(frame.data.tangent_x) >= -UNIT_Q14 &&
			$signed(frame.data.normal_z) <= UNIT_Q14 &&
			$signed(frame.data.normal_z) >= -UNIT_Q14)
		else $error("Unit vector component out of range.");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |=> frame.valid)
		else $error("Result register loaded without a valid transfer.");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_en |-> !vtx.ready)
		else $error("Vertex accepted while the frame is in work.");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives mesh vertices into the tangent frame block and checks every frame
// result against a cycle-free integer predictor of the face frame, under
// several phases of source idling and sink stalling.
// ----------------------------------------------------------------------------
module testbench;
	import ttf_pkg::*;

	localparam int N_PHASES = 5;

	logic clk;
	logic arst_n;

	ttf_stream_if #(.data_t(vtx_t))   vtx();
	ttf_stream_if #(.data_t(frame_t)) frame();

	triangle_tangent_frame u_top (
		.clk(clk),
		.arst_n(arst_n),
		.vtx(vtx),
		.frame(frame)
	);

	vtx_t   pending_vtx[$];
	frame_t expected_frames[$];
	coord_t held_first;
	coord_t held_second;
	logic [1:0] slot;
	int     errors;
	int     phase;
	int     hold_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [127:0] abs128(logic signed [127:0] a);
		return a[127] ? -a : a;
	endfunction

	// Normalizes one vector to Q1.14; returns 0 when it has zero length.
	function automatic bit unit_vec(input logic signed [127:0] c[3], input bit flip,
			output logic signed [15:0] o[3]);
		logic [127:0] mag[3];
		logic [127:0] all;
		logic [63:0]  m[3];
		logic [63:0]  s;
		logic [63:0]  len;
		logic [63:0]  q;
		int bl;
		all = 0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = abs128(c[k]);
			all |= mag[k];
		end
		bl = 0;
		for (int i = 0; i < 128; i++)
			if (all[i]) bl = i + 1;
		if (bl == 0)
			return 0;
		s = 0;
		for (int k = 0; k < 3; k++) begin
			m[k] = (bl > 31) ? 64'(mag[k] >> (bl - 31)) : 64'(mag[k] << (31 - bl));
			s += m[k] * m[k];
		end
		len = 0;
		for (int i = 31; i >= 0; i--)
			if ((len | (64'd1 << i)) * (len | (64'd1 << i)) <= s)
				len |= 64'd1 << i;
		for (int k = 0; k < 3; k++) begin
			q = (m[k] * UNIT_Q14 + (len >> 1)) / len;
			o[k] = ((c[k][127]) != flip) ? -16'(q) : 16'(q);
		end
		return 1;
	endfunction

	function automatic frame_t face_frame(coord_t p1, coord_t p2, coord_t p3);
		logic signed [127:0] e1[3], e2[3], tv[3], bv[3], nv[3];
		logic signed [127:0] du1, dv1, du2, dv2, det;
		logic signed [15:0]  t[3], b[3], n[3];
		frame_t f;
		bit ok;
		e1[0] = 128'(p2.x) - 128'(p1.x);
		e1[1] = 128'(p2.y) - 128'(p1.y);
		e1[2] = 128'(p2.z) - 128'(p1.z);
		e2[0] = 128'(p3.x) - 128'(p1.x);
		e2[1] = 128'(p3.y) - 128'(p1.y);
		e2[2] = 128'(p3.z) - 128'(p1.z);
		du1 = 128'(p2.u) - 128'(p1.u);
		dv1 = 128'(p2.v) - 128'(p1.v);
		du2 = 128'(p3.u) - 128'(p1.u);
		dv2 = 128'(p3.v) - 128'(p1.v);
		det = du1 * dv2 - du2 * dv1;
		for (int k = 0; k < 3; k++) begin
			tv[k] = dv2 * e1[k] - dv1 * e2[k];
			bv[k] = du1 * e2[k] - du2 * e1[k];
		end
		ok = det != 0;
		if (ok) ok = unit_vec(tv, det[127], t);
		if (ok) ok = unit_vec(bv, det[127], b);
		if (ok) begin
			nv[0] = 128'(t[1]) * 128'(b[2]) - 128'(t[2]) * 128'(b[1]);
			nv[1] = 128'(t[2]) * 128'(b[0]) - 128'(t[0]) * 128'(b[2]);
			nv[2] = 128'(t[0]) * 128'(b[1]) - 128'(t[1]) * 128'(b[0]);
			ok = unit_vec(nv, 1'b0, n);
		end
		f = '0;
		f.degenerate = !ok;
		if (ok) begin
			f.tangent_x = t[0];  f.tangent_y = t[1];  f.tangent_z = t[2];
			f.binormal_x = b[0]; f.binormal_y = b[1]; f.binormal_z = b[2];
			f.normal_x = n[0];   f.normal_y = n[1];   f.normal_z = n[2];
		end
		return f;
	endfunction

	function automatic coord_t to_coord(vtx_t v);
		coord_t c;
		c.x = v.pos_x; c.y = v.pos_y; c.z = v.pos_z; c.u = v.tex_u; c.v = v.tex_v;
		return c;
	endfunction

	task automatic accept_vertex(vtx_t v);
		case (slot)
			2'd1: begin
				held_second = to_coord(v);
				slot = 2'd2;
			end
			2'd2: begin
				expected_frames.insert(expected_frames.size(),
					face_frame(held_first, held_second, to_coord(v)));
				slot = 2'd0;
			end
			default: begin
				held_first = to_coord(v);
				slot = 2'd1;
			end
		endcase
		if (v.end_of_mesh)
			slot = 2'd0;
	endtask

	task automatic queue_vertex(vtx_t v);
		pending_vtx.insert(pending_vtx.size(), v);
	endtask

	function automatic logic [31:0] rand_coord(int style);
		case (style)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
			2: return 32'($signed($urandom_range(0, 64)) - 32);
			default: return ($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000)
					^ $urandom_range(0, 3);
		endcase
	endfunction

	function automatic vtx_t rand_vtx(int style, bit eom);
		vtx_t v;
		v.pos_x = rand_coord(style);
		v.pos_y = rand_coord(style);
		v.pos_z = rand_coord(style);
		v.tex_u = rand_coord(style);
		v.tex_v = rand_coord(style);
		v.end_of_mesh = eom;
		return v;
	endfunction

	function automatic vtx_t mk(logic [31:0] x, y, z, u, w, bit eom);
		vtx_t v;
		v.pos_x = x; v.pos_y = y; v.pos_z = z; v.tex_u = u; v.tex_v = w;
		v.end_of_mesh = eom;
		return v;
	endfunction

	task automatic add_directed();
		localparam logic [31:0] ONE = 32'h0001_0000;
		localparam logic [31:0] MAXV = 32'h7fff_ffff;
		localparam logic [31:0] MINV = 32'h8000_0000;
		// A well-formed unit triangle.
		queue_vertex(mk(0, 0, 0, 0, 0, 0));
		queue_vertex(mk(ONE, 0, 0, ONE, 0, 0));
		queue_vertex(mk(0, ONE, 0, 0, ONE, 1));
		// Negative determinant flips tangent and binormal.
		queue_vertex(mk(0, 0, 0, 0, 0, 0));
		queue_vertex(mk(ONE, 0, 0, 0, ONE, 0));
		queue_vertex(mk(0, ONE, 0, ONE, 0, 0));
		// Zero determinant.
		queue_vertex(mk(0, 0, 0, 5, 5, 0));
		queue_vertex(mk(ONE, 0, 0, 5, 5, 0));
		queue_vertex(mk(0, ONE, 0, 9, 9, 0));
		// Zero-length tangent and binormal: coincident positions.
		queue_vertex(mk(7, 7, 7, 0, 0, 0));
		queue_vertex(mk(7, 7, 7, ONE, 0, 0));
		queue_vertex(mk(7, 7, 7, 0, ONE, 0));
		// Extreme coordinates.
		queue_vertex(mk(MINV, MAXV, MINV, MINV, MINV, 0));
		queue_vertex(mk(MAXV, MINV, MAXV, MAXV, MINV, 0));
		queue_vertex(mk(MINV, MINV, MAXV, MINV, MAXV, 0));
		// Incomplete triangles dropped by end of mesh.
		queue_vertex(mk(1, 2, 3, 4, 5, 1));
		queue_vertex(mk(1, 2, 3, 4, 5, 0));
		queue_vertex(mk(MAXV, MAXV, MAXV, MAXV, MAXV, 1));
		// Parallel tangent and binormal give a zero normal.
		queue_vertex(mk(0, 0, 0, 0, 0, 0));
		queue_vertex(mk(ONE, 0, 0, ONE, 0, 0));
		queue_vertex(mk(2 * ONE, 0, 0, 0, ONE, 1));
	endtask

	task automatic add_random(int count);
		int style;
		for (int i = 0; i < count; i += 3) begin
			style = $urandom_range(0, 9);
			style = (style < 3) ? 0 : (style < 7) ? 1 : (style < 9) ? 2 : 3;
			if ($urandom_range(0, 19) == 0) begin
				queue_vertex(rand_vtx(style, $urandom_range(0, 1) == 1));
			end else begin
				queue_vertex(rand_vtx(style, 0));
				queue_vertex(rand_vtx(style, 0));
				queue_vertex(rand_vtx(style, $urandom_range(0, 3) == 0));
			end
		end
	endtask

	function automatic bit idle_roll(int p, bit sink_side);
		case (p)
			1: return !sink_side && $urandom_range(0, 99) < 69;
			2: return sink_side && $urandom_range(0, 99) < 69;
			3: return $urandom_range(0, 99) < 8;
			default: return 0;
		endcase
	endfunction

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx.valid <= 1'b0;
		end else if (!vtx.valid || vtx.ready) begin
			if (pending_vtx.size() != 0 && !idle_roll(phase, 0)) begin
				vtx.data  <= pending_vtx.pop_front();
				vtx.valid <= 1'b1;
			end else begin
				vtx.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			frame.ready <= 1'b0;
		end else begin
			frame.ready <= arst_n && !idle_roll(phase, 1);
		end
	end

	always @(posedge clk) begin
		frame_t exp_f;
		if (arst_n && vtx.valid && vtx.ready)
			accept_vertex(vtx.data);
		if (arst_n && frame.valid && frame.ready) begin
			if (expected_frames.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected frame transfer: %p", frame.data);
			end else begin
				exp_f = expected_frames.pop_front();
				if (frame.data !== exp_f) begin
					errors++;
					if (errors <= 10)
						$display("frame mismatch: expected %p, got %p", exp_f, frame.data);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		vtx.valid = 1'b0;
		vtx.data = '0;
		frame.ready = 1'b0;
		errors = 0;
		phase = 0;
		hold_cycles = 0;
		slot = 2'd0;
		held_first = '0;
		held_second = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		add_directed();
		for (int p = 0; p < N_PHASES; p++) begin
			phase = p % 4;
			add_random(340);
			if (p == 4) begin
				@(negedge clk);
				hold_cycles = 3000;
			end
			while (pending_vtx.size() != 0 || vtx.valid)
				@(posedge clk);
		end
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		if (errors == 0 && expected_frames.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
rtl/ttf_pkg.sv
rtl/ttf_stream_if.sv
rtl/ttf_dp.sv
rtl/ttf_ctrl.sv
rtl/triangle_tangent_frame.sv
bench/testbench.sv
